### sv/met_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
// Beat structs, configuration register codes and reset values.
// No dependencies.
package met_pkg;

    // Field widths fixed by the interface
    localparam int PIX_INDEX_W     = 12;
    localparam int INDEX_WIDTH_MAX = 16;
    localparam int COUNT_W         = 15;
    localparam int RADIUS_W        = 12;
    localparam int COORD_W         = 32;
    localparam int STEP_W          = 31;
    localparam int CHAR_W          = 7;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_X   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_Y   = 3'd5;

    // Reset values
    localparam logic [COUNT_W-1:0]         RST_MAX_ITER = 15'd1000;
    localparam logic [RADIUS_W-1:0]        RST_RADIUS   = 12'd1000;
    localparam logic signed [COORD_W-1:0]  RST_ORIGIN_X = -32'sd563714458;
    localparam logic signed [COORD_W-1:0]  RST_ORIGIN_Y = -32'sd322122547;
    localparam logic [STEP_W-1:0]          RST_STEP_X   = 31'd4160749;
    localparam logic [STEP_W-1:0]          RST_STEP_Y   = 31'd6442451;

    // Display character: base code and last residue of the mod-94 counter
    localparam logic [CHAR_W-1:0] CHAR_BASE    = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_MOD_TOP = 7'd93;

    // Integer bits allowed in a new z part before it escapes outright
    localparam int MAG_INT_BITS = 12;

    // Digit width of the digit-serial multipliers
    localparam int MUL_DIGIT_W = 16;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PIX_INDEX_W-1:0] column;
        logic [PIX_INDEX_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_W-1:0] iterations;
        logic               escaped;
        logic [CHAR_W-1:0]  char_code;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [STEP_W-1:0]         step_x;
        logic [STEP_W-1:0]         step_y;
    } front_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  max_iter;
        logic [RADIUS_W-1:0] radius;
    } core_cfg_t;

endpackage

### sv/met_front.sv
// Front end: takes pixel beats and forms the point c = origin + index * step.
// Holds one point until the queue takes it. Uses met_pkg.
module met_front #(
    parameter int IW = 12,
    parameter int CW = 45
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  met_pkg::pixel_t     pixel,
    input  met_pkg::front_cfg_t cfg,
    input  logic                full,
    output logic                push,
    output logic [2*CW-1:0]     push_data
);

    logic [met_pkg::INDEX_WIDTH_MAX-1:0] col_ext;
    logic [met_pkg::INDEX_WIDTH_MAX-1:0] row_ext;
    logic [IW-1:0]                       col_idx;
    logic [IW-1:0]                       row_idx;
    logic [IW+met_pkg::STEP_W-1:0]       prod_x;
    logic [IW+met_pkg::STEP_W-1:0]       prod_y;
    logic signed [CW-1:0]                cx_next;
    logic signed [CW-1:0]                cy_next;
    logic signed [CW-1:0]                cx_reg;
    logic signed [CW-1:0]                cy_reg;
    logic                                hold_reg;
    logic                                hold_next;
    logic                                accept;

    // Index masked to the configured index width
    assign col_ext = {{(met_pkg::INDEX_WIDTH_MAX-met_pkg::PIX_INDEX_W){1'b0}}, pixel.column};
    assign row_ext = {{(met_pkg::INDEX_WIDTH_MAX-met_pkg::PIX_INDEX_W){1'b0}}, pixel.row};
    assign col_idx = col_ext[IW-1:0];
    assign row_idx = row_ext[IW-1:0];

    // c = origin + index * step, exact
    assign prod_x  = col_idx * cfg.step_x;
    assign prod_y  = row_idx * cfg.step_y;
    assign cx_next = CW'($signed(cfg.origin_x)) + $signed({2'b00, prod_x});
    assign cy_next = CW'($signed(cfg.origin_y)) + $signed({2'b00, prod_y});

    // Handshake: one point held, freed when the queue takes it
    assign push        = hold_reg && !full;
    assign pixel_stall = hold_reg && full;
    assign accept      = pixel_valid && !pixel_stall;
    assign push_data   = {cx_reg, cy_reg};

    always_comb
    begin
        hold_next = hold_reg;
        if (accept)
        begin
            hold_next = 1'b1;
        end
        else if (push)
        begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    // Point registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

endmodule

### sv/met_queue.sv
// Short queue of points between the front end and the iteration core.
// Register file with read and write pointers. No dependencies.
module met_queue #(
    parameter int WIDTH = 90,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign valid   = (count_reg != '0);
    assign data    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/met_core.sv
// Iteration core: runs z = z^2 + c on one point with three digit-serial
// multipliers and holds the result beat. Uses met_pkg.
module met_core #(
    parameter int F  = 28,
    parameter int CW = 45
) (
    input  logic               clk,
    input  logic               rst_n,
    input  met_pkg::core_cfg_t cfg,
    input  logic               q_valid,
    input  logic [2*CW-1:0]    q_data,
    output logic               q_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output met_pkg::result_t   result
);

    // Operand width covers both the first point and any non-escaped z
    localparam int MW   = (CW > F + met_pkg::MAG_INT_BITS + 1) ? CW
                                                               : F + met_pkg::MAG_INT_BITS + 1;
    localparam int DW   = met_pkg::MUL_DIGIT_W;
    localparam int NDIG = (MW + DW - 1) / DW;
    localparam int BW   = NDIG * DW;
    localparam int PW   = MW + BW;
    localparam int SW   = PW + 2;
    localparam int KW   = $clog2(NDIG + 1);
    localparam int RRW  = 2 * met_pkg::RADIUS_W;
    localparam int SMB  = met_pkg::MAG_INT_BITS + F;
    localparam logic [KW-1:0] K_LAST = KW'(NDIG - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [met_pkg::COUNT_W-1:0]  iter_reg, iter_next;
    logic [met_pkg::CHAR_W-1:0]   mod_reg, mod_next;
    logic                         pend_reg, pend_next;
    logic                         out_valid_reg, out_valid_next;

    logic [MW-1:0]                x_mag_reg, x_mag_next, y_mag_reg, y_mag_next;
    logic                         x_neg_reg, x_neg_next, y_neg_reg, y_neg_next;
    logic [BW-1:0]                bx_reg, bx_next, by_reg, by_next;
    logic [PW-1:0]                xx_reg, xx_next, yy_reg, yy_next, xy_reg, xy_next;
    logic signed [CW-1:0]         cx_reg, cx_next, cy_reg, cy_next;
    logic [RRW-1:0]               rr_reg, rr_next;
    logic [met_pkg::COUNT_W-1:0]  res_iter_reg, res_iter_next;
    logic                         res_esc_reg, res_esc_next;
    logic [met_pkg::CHAR_W-1:0]   res_mod_reg, res_mod_next;
    met_pkg::result_t             out_reg, out_next;

    logic signed [CW-1:0]         cx_q, cy_q;
    logic                         load;
    logic [MW-1:0]                x_ld, y_ld, x_ld_mag, y_ld_mag;
    logic [MW+DW-1:0]             px_x, px_y, px_xy;
    logic [PW:0]                  mag_sum, lim_ext;
    logic                         mag_esc;
    logic signed [SW-1:0]         d_w, p_w, nx_w, ny_w;
    logic [SW-1:0]                p_mag;
    logic [SW-1-SMB:0]            nx_hi, ny_hi;
    logic                         small_x, small_y;
    logic [met_pkg::COUNT_W-1:0]  ic;
    logic [met_pkg::CHAR_W-1:0]   ic_mod;
    logic                         out_free;

    assign cx_q = q_data[2*CW-1:CW];
    assign cy_q = q_data[CW-1:0];

    // Digit-serial partial products, most significant digit first
    assign px_x  = x_mag_reg * bx_reg[BW-1 -: DW];
    assign px_y  = y_mag_reg * by_reg[BW-1 -: DW];
    assign px_xy = x_mag_reg * by_reg[BW-1 -: DW];

    // Escape test on |z|^2 against radius^2 scaled by 2^(2F)
    assign mag_sum = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign lim_ext = {{(PW+1-RRW-2*F){1'b0}}, rr_reg, {(2*F){1'b0}}};
    assign mag_esc = mag_sum > lim_ext;

    // New z: floor((x^2 - y^2) / 2^F) + cx and floor(2xy / 2^F) + cy
    assign d_w   = $signed({2'b00, xx_reg}) - $signed({2'b00, yy_reg});
    assign p_mag = {1'b0, xy_reg, 1'b0};
    assign p_w   = (x_neg_reg ^ y_neg_reg) ? -$signed(p_mag) : $signed(p_mag);
    assign nx_w  = (d_w >>> F) + SW'(cx_reg);
    assign ny_w  = (p_w >>> F) + SW'(cy_reg);

    // Magnitude below 2^(12+F), otherwise escape at once
    assign nx_hi   = nx_w[SW-1:SMB];
    assign ny_hi   = ny_w[SW-1:SMB];
    assign small_x = (~|nx_hi) || ((&nx_hi) && (|nx_w[SMB-1:0]));
    assign small_y = (~|ny_hi) || ((&ny_hi) && (|ny_w[SMB-1:0]));

    // Count after the pending magnitude check passes, with its mod-94 residue
    assign ic     = pend_reg ? met_pkg::COUNT_W'(iter_reg + 1'b1) : iter_reg;
    assign ic_mod = !pend_reg ? mod_reg
                  : (mod_reg == met_pkg::CHAR_MOD_TOP) ? '0
                  : met_pkg::CHAR_W'(mod_reg + 1'b1);

    // Operand load: the point itself, or the new z
    assign x_ld     = (state_reg == S_IDLE) ? MW'(cx_q) : nx_w[MW-1:0];
    assign y_ld     = (state_reg == S_IDLE) ? MW'(cy_q) : ny_w[MW-1:0];
    assign x_ld_mag = x_ld[MW-1] ? MW'(~x_ld + 1'b1) : x_ld;
    assign y_ld_mag = y_ld[MW-1] ? MW'(~y_ld + 1'b1) : y_ld;

    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        iter_next      = iter_reg;
        mod_next       = mod_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && result_stall;
        x_mag_next     = x_mag_reg;
        y_mag_next     = y_mag_reg;
        x_neg_next     = x_neg_reg;
        y_neg_next     = y_neg_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rr_next        = rr_reg;
        res_iter_next  = res_iter_reg;
        res_esc_next   = res_esc_reg;
        res_mod_next   = res_mod_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        load           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cx_next   = cx_q;
                    cy_next   = cy_q;
                    rr_next   = RRW'(cfg.radius) * RRW'(cfg.radius);
                    iter_next = '0;
                    mod_next  = '0;
                    pend_next = 1'b0;
                    if (cfg.max_iter == '0)
                    begin
                        res_iter_next = '0;
                        res_esc_next  = 1'b0;
                        res_mod_next  = '0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        load       = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                bx_next = bx_reg << DW;
                by_next = by_reg << DW;
                xx_next = (xx_reg << DW) + PW'(px_x);
                yy_next = (yy_reg << DW) + PW'(px_y);
                xy_next = (xy_reg << DW) + PW'(px_xy);
                k_next  = KW'(k_reg + 1'b1);
                if (k_reg == K_LAST)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (pend_reg && mag_esc)
                begin
                    res_iter_next = iter_reg;
                    res_esc_next  = 1'b1;
                    res_mod_next  = mod_reg;
                    state_next    = S_DONE;
                end
                else if (pend_reg && (ic == cfg.max_iter))
                begin
                    res_iter_next = ic;
                    res_esc_next  = 1'b0;
                    res_mod_next  = ic_mod;
                    state_next    = S_DONE;
                end
                else if (!small_x || !small_y)
                begin
                    res_iter_next = ic;
                    res_esc_next  = 1'b1;
                    res_mod_next  = ic_mod;
                    state_next    = S_DONE;
                end
                else
                begin
                    iter_next  = ic;
                    mod_next   = ic_mod;
                    pend_next  = 1'b1;
                    load       = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.iterations = res_iter_reg;
                    out_next.escaped    = res_esc_reg;
                    out_next.char_code  = res_esc_reg
                                        ? met_pkg::CHAR_W'(met_pkg::CHAR_BASE + res_mod_reg)
                                        : met_pkg::CHAR_BASE;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Fresh operands: magnitudes, digit shifters, cleared accumulators
        if (load)
        begin
            x_mag_next = x_ld_mag;
            y_mag_next = y_ld_mag;
            x_neg_next = x_ld[MW-1];
            y_neg_next = y_ld[MW-1];
            bx_next    = BW'(x_ld_mag);
            by_next    = BW'(y_ld_mag);
            xx_next    = '0;
            yy_next    = '0;
            xy_next    = '0;
            k_next     = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            iter_reg      <= '0;
            mod_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            iter_reg      <= iter_next;
            mod_reg       <= mod_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        x_mag_reg    <= x_mag_next;
        y_mag_reg    <= y_mag_next;
        x_neg_reg    <= x_neg_next;
        y_neg_reg    <= y_neg_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        xx_reg       <= xx_next;
        yy_reg       <= yy_next;
        xy_reg       <= xy_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        rr_reg       <= rr_next;
        res_iter_reg <= res_iter_next;
        res_esc_reg  <= res_esc_next;
        res_mod_reg  <= res_mod_next;
        out_reg      <= out_next;
    end

    // Checks
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_reg <= met_pkg::CHAR_MOD_TOP)
        else $error("mod-94 residue out of range");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (k_reg < KW'(NDIG)))
        else $error("multiplier digit count overran");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not placed in output register");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != S_IDLE))
        else $error("point taken from queue but core stayed idle");

endmodule

### sv/mandelbrot_escape_time_pixel_top.sv
// Top level of the Mandelbrot escape-time pixel block.
// Configuration registers and the front / queue / core chain. Uses met_pkg,
// met_front, met_queue and met_core.
//
// Each pixel beat (column, row) gives one result beat. The front end forms c
// combinationally, registers it and parks it in a two-entry queue, so pixels
// can be taken while the core still iterates or a result waits. The core works
// on one pixel at a time: each z = z^2 + c step runs a digit loop over the NDIG
// digits of its 16-bit digit-serial multipliers (3 at the default parameters)
// and then an update. A pixel escapes through the magnitude test or the integer
// range check; the default iteration limit is 1000.
// Configuration writes are always taken (ready is tied high) and must be made
// while the block is idle.
module mandelbrot_escape_time_pixel_top #(
    parameter int COORD_FRAC_BITS = 28,
    parameter int INDEX_WIDTH     = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  met_pkg::pixel_t                    pixel,
    output logic                               result_valid,
    input  logic                               result_stall,
    output met_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [met_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Point width: origin plus index times step, signed
    localparam int CW = INDEX_WIDTH + met_pkg::STEP_W + 2;

    logic [met_pkg::COUNT_W-1:0]        max_iter_reg;
    logic [met_pkg::RADIUS_W-1:0]       radius_reg;
    logic signed [met_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [met_pkg::COORD_W-1:0] origin_y_reg;
    logic [met_pkg::STEP_W-1:0]         step_x_reg;
    logic [met_pkg::STEP_W-1:0]         step_y_reg;
    logic                               cfg_write;
    met_pkg::front_cfg_t                front_cfg;
    met_pkg::core_cfg_t                 core_cfg;
    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_valid;
    logic [2*CW-1:0]                    q_push_data;
    logic [2*CW-1:0]                    q_data;

    // Configuration register bank
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= met_pkg::RST_MAX_ITER;
            radius_reg   <= met_pkg::RST_RADIUS;
            origin_x_reg <= met_pkg::RST_ORIGIN_X;
            origin_y_reg <= met_pkg::RST_ORIGIN_Y;
            step_x_reg   <= met_pkg::RST_STEP_X;
            step_y_reg   <= met_pkg::RST_STEP_Y;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                met_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[met_pkg::COUNT_W-1:0];
                met_pkg::CFG_RADIUS:   radius_reg   <= cfg_data[met_pkg::RADIUS_W-1:0];
                met_pkg::CFG_ORIGIN_X: origin_x_reg <= $signed(cfg_data);
                met_pkg::CFG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data);
                met_pkg::CFG_STEP_X:   step_x_reg   <= cfg_data[met_pkg::STEP_W-1:0];
                met_pkg::CFG_STEP_Y:   step_y_reg   <= cfg_data[met_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign front_cfg.origin_x = origin_x_reg;
    assign front_cfg.origin_y = origin_y_reg;
    assign front_cfg.step_x   = step_x_reg;
    assign front_cfg.step_y   = step_y_reg;
    assign core_cfg.max_iter  = max_iter_reg;
    assign core_cfg.radius    = radius_reg;

    // Front end: point formation
    met_front #(
        .IW (INDEX_WIDTH),
        .CW (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .cfg         (front_cfg),
        .full        (q_full),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    // Point queue
    met_queue #(
        .WIDTH (2 * CW),
        .DEPTH (met_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    // Iteration core and result register
    met_core #(
        .F  (COORD_FRAC_BITS),
        .CW (CW)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (core_cfg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
